FILE: rtl/circular_buffer_deque_top_macros.svh
// ----------------------------------------------------------------------------
// Circular buffer deque assertion macros
// Shared concurrent assertion forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BUFFER_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_BUFFER_DEQUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Circular buffer deque package
// Sizes, command and status codes, shared types and index helpers.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W      = 5;
    localparam int CNT_W      = 5;
    localparam int MODE_W     = 3;
    localparam int STAT_W     = 2;
    localparam int SUM_W      = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [MODE_W-1:0] MODE_PUSH_LEFT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_RIGHT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_LEFT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_RIGHT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wr_data;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic              is_pop;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_res;

    function automatic logic [CAP_W-1:0] f_eff_cap(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] eff;
        eff = cap;
        if (cap == '0) begin
            eff = CAP_W'(1);
        end else if (int'(cap) > DEPTH) begin
            eff = CAP_W'(DEPTH);
        end
        return eff;
    endfunction

    function automatic logic [ADDR_W-1:0] f_mid(input logic [CAP_W-1:0] eff);
        return ADDR_W'(eff >> 1);
    endfunction

    function automatic logic [ADDR_W-1:0] f_step_left(input logic [ADDR_W-1:0] idx,
                                                      input logic [CAP_W-1:0] eff);
        logic [ADDR_W-1:0] nxt;
        if (idx == '0) begin
            nxt = ADDR_W'(eff - 1'b1);
        end else begin
            nxt = idx - 1'b1;
        end
        return nxt;
    endfunction

    function automatic logic [ADDR_W-1:0] f_step_right(input logic [ADDR_W-1:0] idx,
                                                       input logic [CAP_W-1:0] eff);
        logic [SUM_W-1:0]  sum;
        logic [ADDR_W-1:0] nxt;
        sum = SUM_W'(idx) + SUM_W'(1);
        if (sum >= SUM_W'(eff)) begin
            nxt = '0;
        end else begin
            nxt = ADDR_W'(sum);
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/cbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/cbd_ctrl.sv
// ----------------------------------------------------------------------------
// Circular buffer deque control
// Holds capacity, end indices and element count, decodes each command and
// issues the one store access it needs.
// ----------------------------------------------------------------------------
module cbd_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [cbd_pkg::MODE_W-1:0]       i_mode,
    input  logic [cbd_pkg::DATA_WIDTH-1:0]   i_value,
    input  logic                             i_cfg_wr,
    input  logic [cbd_pkg::CAP_W-1:0]        i_cfg_data,
    output cbd_pkg::t_ram_req                o_ram_req,
    output cbd_pkg::t_res                    o_res
);

    logic [cbd_pkg::CAP_W-1:0]  r_cap;
    logic [cbd_pkg::ADDR_W-1:0] r_left;
    logic [cbd_pkg::ADDR_W-1:0] r_right;
    logic [cbd_pkg::CNT_W-1:0]  r_count;
    cbd_pkg::t_res              r_res;

    logic [cbd_pkg::CAP_W-1:0]  eff_cap;
    logic [cbd_pkg::ADDR_W-1:0] n_left;
    logic [cbd_pkg::ADDR_W-1:0] n_right;
    logic [cbd_pkg::CNT_W-1:0]  n_count;
    cbd_pkg::t_res              n_res;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_write;

    assign eff_cap  = cbd_pkg::f_eff_cap(r_cap);
    assign is_full  = ({1'b0, r_count} >= {1'b0, eff_cap});
    assign is_empty = (r_count == '0);

    always_comb begin
        n_left         = r_left;
        n_right        = r_right;
        n_count        = r_count;
        do_write       = 1'b0;
        o_ram_req.addr = r_left;
        n_res.valid    = i_accept;
        n_res.is_pop   = 1'b0;
        n_res.status   = cbd_pkg::ST_OK;
        case (i_mode)
            cbd_pkg::MODE_PUSH_LEFT: begin
                if (is_full) begin
                    n_res.status = cbd_pkg::ST_OVERFLOW;
                end else begin
                    n_left         = cbd_pkg::f_step_left(r_left, eff_cap);
                    o_ram_req.addr = n_left;
                    do_write       = 1'b1;
                    n_count        = r_count + 1'b1;
                end
            end
            cbd_pkg::MODE_PUSH_RIGHT: begin
                if (is_full) begin
                    n_res.status = cbd_pkg::ST_OVERFLOW;
                end else begin
                    o_ram_req.addr = r_right;
                    n_right        = cbd_pkg::f_step_right(r_right, eff_cap);
                    do_write       = 1'b1;
                    n_count        = r_count + 1'b1;
                end
            end
            cbd_pkg::MODE_POP_LEFT: begin
                if (is_empty) begin
                    n_res.status = cbd_pkg::ST_EMPTY;
                end else begin
                    o_ram_req.addr = r_left;
                    n_left         = cbd_pkg::f_step_right(r_left, eff_cap);
                    n_res.is_pop   = 1'b1;
                    n_count        = r_count - 1'b1;
                end
            end
            cbd_pkg::MODE_POP_RIGHT: begin
                if (is_empty) begin
                    n_res.status = cbd_pkg::ST_EMPTY;
                end else begin
                    n_right        = cbd_pkg::f_step_left(r_right, eff_cap);
                    o_ram_req.addr = n_right;
                    n_res.is_pop   = 1'b1;
                    n_count        = r_count - 1'b1;
                end
            end
            cbd_pkg::MODE_CLEAR: begin
                n_left  = cbd_pkg::f_mid(eff_cap);
                n_right = cbd_pkg::f_mid(eff_cap);
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_res.count       = n_count;
        o_ram_req.wr_en   = i_accept && do_write && i_rst_n;
        o_ram_req.wr_data = i_value;
    end

    always_ff @(posedge i_clk) begin
        r_res.is_pop <= n_res.is_pop;
        r_res.status <= n_res.status;
        r_res.count  <= n_res.count;
        if (!i_rst_n) begin
            r_cap       <= cbd_pkg::CAP_RESET;
            r_left      <= cbd_pkg::f_mid(cbd_pkg::f_eff_cap(cbd_pkg::CAP_RESET));
            r_right     <= cbd_pkg::f_mid(cbd_pkg::f_eff_cap(cbd_pkg::CAP_RESET));
            r_count     <= '0;
            r_res.valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cap <= i_cfg_data;
            end
            if (i_accept) begin
                r_left  <= n_left;
                r_right <= n_right;
                r_count <= n_count;
            end
            r_res.valid <= n_res.valid;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/circular_buffer_deque_top.sv
// ----------------------------------------------------------------------------
// Circular buffer deque top level
// Double-ended queue of up to sixteen 32-bit entries kept in a ring RAM.
// ----------------------------------------------------------------------------
// Commands arrive on i_mode and i_value and transfer at a rising edge where
// start is high and busy is low. Modes are push left, push right, pop left,
// pop right and clear; unused modes change nothing and report ok.
// busy stays low, so a command can transfer in every cycle: one command per
// cycle is the sustained throughput, set by the single RAM port.
// The result of a command appears on o_popped_value, o_status and o_count
// for exactly one cycle, marked by o_strobe, after the registered RAM read
// and control result and then the output register. The receiver cannot
// stall, and results are never held back. The capacity register is written
// through i_cfg_valid, o_cfg_ready and i_cfg_data; the user must do so only
// while no command is in flight, as the block itself does not enforce it;
// issue a clear after a change. Synchronous reset empties the deque, sets
// capacity to sixteen and puts both ends at the middle. The RAM needs no
// clearing pass, since only written entries are ever read.
// ----------------------------------------------------------------------------
module circular_buffer_deque_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cbd_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [cbd_pkg::DATA_WIDTH-1:0] i_value,
    output logic                             o_strobe,
    output logic signed [cbd_pkg::DATA_WIDTH-1:0] o_popped_value,
    output logic [cbd_pkg::STAT_W-1:0]       o_status,
    output logic [cbd_pkg::CNT_W-1:0]        o_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbd_pkg::CAP_W-1:0]        i_cfg_data
);

    cbd_pkg::t_ram_req                   ram_req;
    cbd_pkg::t_res                       res;
    logic [cbd_pkg::DATA_WIDTH-1:0]      rd_data;
    logic                                accept;

    logic                                r_strobe;
    logic [cbd_pkg::DATA_WIDTH-1:0]      r_popped;
    logic [cbd_pkg::STAT_W-1:0]          r_status;
    logic [cbd_pkg::CNT_W-1:0]           r_count;
    logic [cbd_pkg::DATA_WIDTH-1:0]      n_popped;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    cbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_ram_req  (ram_req),
        .o_res      (res)
    );

    cbd_ram #(
        .WIDTH (cbd_pkg::DATA_WIDTH),
        .DEPTH (cbd_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_addr    (ram_req.addr),
        .i_wr_data (ram_req.wr_data),
        .o_rd_data (rd_data)
    );

    assign n_popped = res.is_pop ? rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_status <= res.status;
        r_count  <= res.count;
    end

    assign o_strobe       = r_strobe;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_count        = r_count;

endmodule

FILE: rtl/cbd_checker.sv
// ----------------------------------------------------------------------------
// Circular buffer deque checker
// Port-level checks on command and result timing and result contents.
// ----------------------------------------------------------------------------
`include "circular_buffer_deque_top_macros.svh"

module cbd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_strobe,
    input logic [cbd_pkg::DATA_WIDTH-1:0]   o_popped_value,
    input logic [cbd_pkg::STAT_W-1:0]       o_status,
    input logic [cbd_pkg::CNT_W-1:0]        o_count
);

    logic accept;

    assign accept = start && !busy;

    `CBD_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, accept, ##1 o_strobe, "missing result")
    `CBD_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_strobe && $past(i_rst_n, 2), $past(accept, 2), "result without command")
    `CBD_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_strobe && (o_status != cbd_pkg::ST_OK), o_popped_value == '0, "failed command returned data")
    `CBD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, o_strobe, int'(o_count) <= cbd_pkg::DEPTH, "count above depth")
    `CBD_ASSERT_IMP(a_overflow_full, i_clk, i_rst_n, o_strobe && (o_status == cbd_pkg::ST_OVERFLOW), o_count != '0, "overflow with empty deque")

endmodule

bind circular_buffer_deque_top cbd_checker u_cbd_checker (.*);
